// File: rtl/plgr_pkg.sv
// Package for the peak limiter with gain ramp: gain constants, the register
// reset value, controller state type and controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package plgr_pkg;

  // Gains are unsigned Q1.15, unity is 1 << 15
  localparam int          GAIN_W     = 16;
  localparam logic [15:0] UNITY_GAIN = 16'h8000;
  localparam logic [15:0] HALF_LSB   = 16'h4000;

  // Quotient bits produced by the shared divider
  localparam int          QUOT_W     = 16;

  // ramp_steps register
  localparam int          RS_W       = 5;
  localparam logic [4:0]  RS_RESET   = 5'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CHECK,
    ST_DIV1,
    ST_DIV2,
    ST_RAMP,
    ST_EMIT,
    ST_FLUSH,
    ST_LAST
  } plgr_state_t;

  typedef struct packed {
    logic load_in;
    logic scale;
    logic check;
    logic div1_go;
    logic div2_go;
    logic ramp_init;
    logic ramp_step;
    logic shift_in;
    logic out_hold;
    logic out_x;
    logic out_tap;
    logic flush_init;
    logic flush_step;
    logic clear;
  } plgr_cmd_t;

  typedef struct packed {
    logic peak;
    logic div_busy;
    logic cnt_top;
    logic cnt_zero;
    logic n_zero;
    logic fill_zero;
    logic fill_full;
    logic tap_live;
    logic last;
    logic out_free;
  } plgr_sts_t;

endpackage

`default_nettype wire

// File: rtl/plgr_div.sv
// Restoring divider, one quotient bit per cycle, 16 quotient bits.
// Depends on plgr_pkg for the quotient width.
`default_nettype none

module plgr_div
  import plgr_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [SAMPLE_BITS+11:0] dividend,
  input  wire logic [SAMPLE_BITS-1:0]  divisor,
  output logic                         busy,
  output logic [QUOT_W-1:0]            quotient,
  output logic [SAMPLE_BITS-1:0]       remainder
);

  localparam int SB = SAMPLE_BITS;
  localparam int DW = SB + 12;
  localparam int TW = SB + QUOT_W - 1;
  localparam int BW = $clog2(QUOT_W);

  logic [DW-1:0]     rem_r, rem_nxt;
  logic [TW-1:0]     trial_r;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [BW-1:0]     bit_r;
  logic              busy_r;
  logic [TW-1:0]     rem_ext;
  logic              fits;

  // trial subtract of the shifted divisor
  always_comb begin
    rem_ext  = TW'(rem_r);
    fits     = rem_ext >= trial_r;
    rem_nxt  = fits ? DW'(rem_ext - trial_r) : rem_r;
    quot_nxt = {quot_r[QUOT_W-2:0], fits};
  end

  // control: busy flag and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      bit_r  <= BW'(QUOT_W - 1);
    end else if (busy_r) begin
      bit_r <= bit_r - BW'(1);
      if (bit_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= dividend;
      trial_r <= TW'(divisor) << (QUOT_W - 1);
      quot_r  <= '0;
    end else if (busy_r) begin
      rem_r   <= rem_nxt;
      trial_r <= trial_r >> 1;
      quot_r  <= quot_nxt;
    end
  end

  assign busy      = busy_r;
  assign quotient  = quot_r;
  assign remainder = SB'(rem_r);

endmodule

`default_nettype wire

// File: rtl/plgr_dp.sv
// Datapath: held samples, pending gains, gain multipliers, ramp accumulator,
// output register and the ramp_steps register. Depends on plgr_pkg, plgr_div.
`default_nettype none

module plgr_dp
  import plgr_pkg::*;
#(
  parameter int MAX_STEPS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire plgr_cmd_t                     cmd,
  output plgr_sts_t                          sts,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  wire logic                          in_end_of_track,
  input  wire logic                          cfg_valid,
  input  wire logic [RS_W-1:0]               cfg_ramp_steps,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  output logic                               out_last_out
);

  localparam int SB  = SAMPLE_BITS;
  localparam int DW  = SB + 12;
  localparam int CW  = $clog2(MAX_STEPS + 1);
  localparam int NW  = (CW > RS_W) ? CW : RS_W;
  localparam int DVW = 7;
  localparam int RW  = DVW + 1;
  localparam logic [SB-1:0] FS_S   = SB'(1) << (SB - 4);
  localparam logic [SB-1:0] FS_NEG = ~FS_S + SB'(1);

  // |x| * g rounded half away from zero, sign kept
  function automatic logic [SB-1:0] scale_sample(input logic [SB-1:0] x,
                                                 input logic [GAIN_W-1:0] g);
    logic [SB-1:0]    m;
    logic [SB+15:0]   p;
    logic [SB-1:0]    r;
    m = x[SB-1] ? (~x + SB'(1)) : x;
    p = (SB+16)'(m) * (SB+16)'(g) + (SB+16)'(HALF_LSB);
    r = p[SB+14:15];
    return x[SB-1] ? (~r + SB'(1)) : r;
  endfunction

  // a * b rounded half up, Q1.15
  function automatic logic [GAIN_W-1:0] scale_gain(input logic [GAIN_W-1:0] a,
                                                   input logic [GAIN_W-1:0] b);
    logic [31:0] p;
    p = 32'(a) * 32'(b) + 32'(HALF_LSB);
    return p[30:15];
  endfunction

  logic [SB-1:0]     win_r  [MAX_STEPS];
  logic [GAIN_W-1:0] pend_r [MAX_STEPS];
  logic [CW-1:0]     fill_r;
  logic [CW-1:0]     cnt_r;
  logic [RS_W-1:0]   steps_r;
  logic [SB-1:0]     x_r;
  logic              last_r;
  logic              peak_r;
  logic [GAIN_W-1:0] g_r;
  logic [QUOT_W-1:0] qd_r, q_r;
  logic [DVW-1:0]    rd_r, r_r;
  logic [SB-1:0]     hold_r;
  logic              out_valid_r;
  logic [SB-1:0]     out_data_r;
  logic              out_last_r;

  logic [NW-1:0]     st_ext;
  logic [CW-1:0]     n_c;
  logic [DVW-1:0]    np1, div_c;
  logic [SB-1:0]     mag_w;
  logic              peak_w;
  logic              div_go;
  logic [DW-1:0]     dvd;
  logic [SB-1:0]     dvs;
  logic              div_busy;
  logic [QUOT_W-1:0] quot;
  logic [SB-1:0]     rem;
  logic [GAIN_W-1:0] gj;
  logic [SB-1:0]     win_tail;
  logic [GAIN_W-1:0] pend_tail;
  logic [RW-1:0]     sum0, sum1;
  logic              ge0, ge1;
  logic              out_load;

  // effective step count and ramp divisor 2*(n+1)
  always_comb begin
    st_ext = NW'(steps_r);
    n_c    = (st_ext > NW'(MAX_STEPS)) ? CW'(MAX_STEPS) : CW'(st_ext);
    np1    = DVW'(n_c) + DVW'(1);
    div_c  = DVW'({np1, 1'b0});
  end

  // peak detect on the scaled sample
  always_comb begin
    mag_w  = x_r[SB-1] ? (~x_r + SB'(1)) : x_r;
    peak_w = mag_w > FS_S;
  end

  // shared divider: 1/|x| first, then 2*(1-g) / 2*(n+1)
  always_comb begin
    div_go = cmd.div1_go | cmd.div2_go;
    dvd    = cmd.div1_go ? ((DW'(FS_S) << 15) + DW'(mag_w >> 1))
                         : DW'({UNITY_GAIN - quot, 1'b0});
    dvs    = cmd.div1_go ? mag_w : SB'(div_c);
  end

  plgr_div #(.SAMPLE_BITS(SB)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_go),
    .dividend  (dvd),
    .divisor   (dvs),
    .busy      (div_busy),
    .quotient  (quot),
    .remainder (rem)
  );

  // ramp gain for the neighbor at the head, and the rotated-in values
  always_comb begin
    gj        = g_r + q_r;
    win_tail  = (peak_r && (cnt_r < fill_r)) ? scale_sample(win_r[0], gj) : win_r[0];
    pend_tail = (peak_r && (cnt_r < n_c)) ? scale_gain(pend_r[0], gj) : pend_r[0];
    sum0      = RW'(np1) + RW'(rem[DVW-1:0]);
    ge0       = sum0 >= RW'(div_c);
    sum1      = RW'(r_r) + RW'(rd_r);
    ge1       = sum1 >= RW'(div_c);
  end

  // window, pending gains, fill count and ramp_steps
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_valid || cmd.clear) begin
      for (int k = 0; k < MAX_STEPS; k++) begin
        win_r[k]  <= '0;
        pend_r[k] <= UNITY_GAIN;
      end
      fill_r <= '0;
      if (!rst_n) begin
        steps_r <= RS_RESET;
      end else if (cfg_valid) begin
        steps_r <= cfg_ramp_steps;
      end
    end else if (cmd.scale) begin
      for (int k = 0; k < MAX_STEPS - 1; k++) begin
        pend_r[k] <= pend_r[k+1];
      end
      pend_r[MAX_STEPS-1] <= UNITY_GAIN;
    end else if (cmd.ramp_step) begin
      for (int k = 0; k < MAX_STEPS - 1; k++) begin
        win_r[k]  <= win_r[k+1];
        pend_r[k] <= pend_r[k+1];
      end
      win_r[MAX_STEPS-1]  <= win_tail;
      pend_r[MAX_STEPS-1] <= pend_tail;
    end else if (cmd.flush_step) begin
      for (int k = 1; k < MAX_STEPS; k++) begin
        win_r[k] <= win_r[k-1];
      end
      win_r[0] <= win_r[MAX_STEPS-1];
    end else if (cmd.shift_in) begin
      for (int k = 1; k < MAX_STEPS; k++) begin
        win_r[k] <= win_r[k-1];
      end
      win_r[0] <= x_r;
      if (fill_r < n_c) begin
        fill_r <= fill_r + CW'(1);
      end
    end
  end

  // current sample and its flags
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r    <= in_sample_in;
      last_r <= in_end_of_track;
    end else if (cmd.scale) begin
      x_r <= scale_sample(x_r, pend_r[0]);
    end else if (cmd.check) begin
      peak_r <= peak_w;
      if (peak_w) begin
        x_r <= x_r[SB-1] ? FS_NEG : FS_S;
      end
    end
  end

  // ramp accumulator: q + r/div tracks 2*(1-g)*j + n+1 over 2*(n+1)
  always_ff @(posedge clk) begin
    if (cmd.div2_go) begin
      g_r <= quot;
    end
    if (cmd.ramp_init) begin
      qd_r <= quot;
      rd_r <= rem[DVW-1:0];
      q_r  <= quot + QUOT_W'(ge0);
      r_r  <= ge0 ? DVW'(sum0 - RW'(div_c)) : DVW'(sum0);
    end else if (cmd.ramp_step) begin
      q_r <= q_r + qd_r + QUOT_W'(ge1);
      r_r <= ge1 ? DVW'(sum1 - RW'(div_c)) : DVW'(sum1);
    end
  end

  // pass counter and the delayed sample captured on the way
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.ramp_init) begin
      cnt_r <= '0;
    end else if (cmd.ramp_step) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.flush_init) begin
      cnt_r <= CW'(MAX_STEPS - 1);
    end else if (cmd.flush_step) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ramp_step && (cnt_r == CW'(n_c - CW'(1)))) begin
      hold_r <= win_tail;
    end
  end

  // output register
  assign out_load = cmd.out_hold | cmd.out_x | cmd.out_tap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_hold) begin
      out_data_r <= hold_r;
      out_last_r <= 1'b0;
    end else if (cmd.out_tap) begin
      out_data_r <= win_r[MAX_STEPS-1];
      out_last_r <= 1'b0;
    end else if (cmd.out_x) begin
      out_data_r <= x_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;
  assign out_last_out   = out_last_r;

  // status to the controller
  always_comb begin
    sts.peak      = peak_w;
    sts.div_busy  = div_busy;
    sts.cnt_top   = cnt_r == CW'(MAX_STEPS - 1);
    sts.cnt_zero  = cnt_r == '0;
    sts.n_zero    = n_c == '0;
    sts.fill_zero = fill_r == '0;
    sts.fill_full = fill_r >= n_c;
    sts.tap_live  = cnt_r < fill_r;
    sts.last      = last_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= n_c)
    else $error("fill count above step count");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  a_ramp_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ramp_step && peak_r && (cnt_r < n_c)) |-> (gj <= UNITY_GAIN))
    else $error("ramp gain above unity");

endmodule

`default_nettype wire

// File: rtl/plgr_ctrl.sv
// Controller state machine: sequences scale, peak check, divisions, ramp pass,
// emit and flush. Depends on plgr_pkg.
`default_nettype none

module plgr_ctrl
  import plgr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire plgr_sts_t sts,
  output plgr_cmd_t      cmd
);

  plgr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.peak) begin
          cmd.div1_go = 1'b1;
          state_nxt   = ST_DIV1;
        end else begin
          cmd.ramp_init = 1'b1;
          state_nxt     = ST_RAMP;
        end
      end
      ST_DIV1: begin
        if (!sts.div_busy) begin
          cmd.div2_go = 1'b1;
          state_nxt   = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (!sts.div_busy) begin
          cmd.ramp_init = 1'b1;
          state_nxt     = ST_RAMP;
        end
      end
      ST_RAMP: begin
        cmd.ramp_step = 1'b1;
        if (sts.cnt_top) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        priority if (sts.n_zero || (sts.last && sts.fill_zero)) begin
          if (sts.out_free) begin
            cmd.out_x = 1'b1;
            cmd.clear = sts.last;
            state_nxt = ST_IDLE;
          end
        end else if (sts.last) begin
          cmd.flush_init = 1'b1;
          state_nxt      = ST_FLUSH;
        end else if (sts.fill_full) begin
          if (sts.out_free) begin
            cmd.out_hold = 1'b1;
            cmd.shift_in = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.shift_in = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!sts.tap_live || sts.out_free) begin
          cmd.out_tap    = sts.tap_live;
          cmd.flush_step = 1'b1;
          if (sts.cnt_zero) begin
            state_nxt = ST_LAST;
          end
        end
      end
      ST_LAST: begin
        if (sts.out_free) begin
          cmd.out_x = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/peak_limiter_gain_ramp_core.sv
// Peak limiter with linear gain ramp, signed Q3.(SAMPLE_BITS-4) samples,
// output delayed by ramp_steps samples, capped at MAX_STEPS; end_of_track flushes the
// held window. An item without a peak takes one rotation pass over the held window and
// pending gains through the shared gain multipliers; a peak adds two passes of the
// bit-serial divider. A flush adds a full rotation of the window plus output stalls. A
// new sample is taken only once the last one is done. A ramp_steps write is taken at any time and
// clears the window and pending gains in the same cycle.
// Depends on plgr_pkg, plgr_ctrl, plgr_dp.
`default_nettype none

module peak_limiter_gain_ramp_core
  import plgr_pkg::*;
#(
  parameter int MAX_STEPS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  wire logic                          in_end_of_track,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  output logic                               out_last_out,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [RS_W-1:0]               cfg_ramp_steps
);

  plgr_cmd_t cmd;
  plgr_sts_t sts;
  logic      cfg_xfer;

  // register writes always land
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  plgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plgr_dp #(
    .MAX_STEPS   (MAX_STEPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample_in    (in_sample_in),
    .in_end_of_track (in_end_of_track),
    .cfg_valid       (cfg_xfer),
    .cfg_ramp_steps  (cfg_ramp_steps),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out),
    .out_last_out    (out_last_out)
  );

endmodule

`default_nettype wire

// File: sim/peak_limiter_gain_ramp_core_tb.sv
// Testbench for peak_limiter_gain_ramp_core: random and directed audio tracks,
// a scoreboard class that predicts the limited, delayed output.
// Depends on plgr_pkg and the peak_limiter_gain_ramp_core RTL.
`timescale 1ns / 100ps

module peak_limiter_gain_ramp_core_tb
  import plgr_pkg::*;
();

  localparam int STEPS_MAX  = 16;
  localparam int FULL_SCALE = 4096;
  localparam int UNITY      = 32768;
  localparam int WATCHDOG   = 6000;
  localparam int DRAIN_WAIT = 120;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
  } limited_t;

  // Limiter predictor and store of expected output transfers
  class limiter_scoreboard;
    int unsigned steps_reg;
    longint      window [STEPS_MAX];
    longint      gain_q [STEPS_MAX];
    int unsigned held;
    limited_t    expected_out [$];
    int unsigned errors, results, peaks, tracks;

    function void clear_track();
      for (int k = 0; k < STEPS_MAX; k++) begin
        window[k] = 0;
        gain_q[k] = UNITY;
      end
      held = 0;
    endfunction

    function new();
      steps_reg = RS_RESET;
      clear_track();
    endfunction

    function void set_steps(logic [RS_W-1:0] v);
      steps_reg = v;
      clear_track();
    endfunction

    // round(|x| * gain / 2^15) half away from zero, sign kept
    function longint apply_gain(longint x, longint gain);
      longint m;
      m = (x < 0) ? -x : x;
      m = (m * gain + 16384) >>> 15;
      return (x < 0) ? -m : m;
    endfunction

    function void push(longint s, logic l);
      limited_t e;
      e.sample = s[15:0];
      e.last   = l;
      expected_out.push_back(e);
    endfunction

    function void note_input(logic signed [15:0] s_in, logic eot);
      int unsigned n;
      longint      x, mag, g, up, gj;
      n = (steps_reg > STEPS_MAX) ? STEPS_MAX : steps_reg;
      x = apply_gain(longint'(s_in), gain_q[0]);
      for (int k = 0; k + 1 < n; k++) gain_q[k] = gain_q[k+1];
      if (n > 0) gain_q[n-1] = UNITY;
      // peak: clamp to full scale and ramp the neighbors
      if (x > FULL_SCALE || x < -FULL_SCALE) begin
        peaks++;
        mag = (x < 0) ? -x : x;
        g = (longint'(FULL_SCALE) * UNITY + mag / 2) / mag;
        x = (x < 0) ? -FULL_SCALE : FULL_SCALE;
        for (int j = 1; j <= n; j++) begin
          up = (2 * (UNITY - g) * j + (n + 1)) / (2 * (n + 1));
          gj = g + up;
          if (j - 1 < held) window[j-1] = apply_gain(window[j-1], gj);
          gain_q[j-1] = (gain_q[j-1] * gj + 16384) >>> 15;
        end
      end
      if (eot) tracks++;
      if (n == 0) begin
        push(x, eot);
        if (eot) clear_track();
        return;
      end
      // end of track flushes the held window, oldest first
      if (eot) begin
        for (int k = held; k > 0; k--) push(window[k-1], 1'b0);
        push(x, 1'b1);
        clear_track();
        return;
      end
      if (held >= n) push(window[n-1], 1'b0);
      else held++;
      for (int k = n - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = x;
    endfunction

    function void check_result(logic signed [15:0] s, logic l);
      limited_t e;
      results++;
      if (expected_out.size() == 0) begin
        $error("unexpected output transfer: sample_out %0d last_out %0b", s, l);
        errors++;
        return;
      end
      e = expected_out.pop_front();
      if (s !== e.sample) begin
        $error("sample_out: expected %0d, actual %0d", e.sample, s);
        errors++;
      end
      if (l !== e.last) begin
        $error("last_out: expected %0b, actual %0b", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [15:0]      in_sample_in = '0;
  logic                    in_end_of_track = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [15:0]      out_sample_out;
  logic                    out_last_out;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [RS_W-1:0]         cfg_ramp_steps = '0;

  limiter_scoreboard sb = new();
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned quiet = 0;
  int unsigned n_items = 0;
  int unsigned n_cfg = 0;

  peak_limiter_gain_ramp_core #(.MAX_STEPS(16), .SAMPLE_BITS(16)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_in    (in_sample_in),
    .in_end_of_track (in_end_of_track),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out),
    .out_last_out    (out_last_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_ramp_steps  (cfg_ramp_steps)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor transfers on all channels; watchdog on silence
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_steps(cfg_ramp_steps);
      if (in_valid && in_ready) begin
        sb.note_input(in_sample_in, in_end_of_track);
        n_items++;
      end
      if (out_valid && out_ready) sb.check_result(out_sample_out, out_last_out);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("Timeout: no transfer for %0d cycles", WATCHDOG);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: random ready bursts, one long hold-off on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic signed [15:0] s, logic eot);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_in    <= s;
    in_end_of_track <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_out.size() != 0) @(posedge clk);
  endtask

  // Register written only with the block idle: drain, then outwait the longest item
  task automatic write_steps(logic [RS_W-1:0] v);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_ramp_steps <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  function automatic logic signed [15:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom_range(0, 8192) - 4096);
    if (r < 7) return 16'($urandom_range(0, 24000) - 12000);
    return 16'($urandom());
  endfunction

  task automatic random_tracks(int unsigned count);
    int unsigned sent, len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len && sent < count; i++) begin
        // mostly well-formed tracks, some stray track ends as noise
        send_item(rand_sample(), (i == len - 1) || ($urandom_range(0, 30) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    static logic [RS_W-1:0] steps_plan [6] = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd7, 5'd10};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, peaks of both signs, short tracks (reset steps)
    send_item(16'sd0, 1'b0);
    send_item(16'sd32767, 1'b0);
    send_item(-16'sd32768, 1'b0);
    send_item(16'sd4096, 1'b0);
    send_item(-16'sd4096, 1'b0);
    send_item(16'sd4097, 1'b0);
    send_item(-16'sd4097, 1'b0);
    send_item(16'sd1, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'sd100, 1'b1);
    send_item(16'sd5000, 1'b0);
    send_item(16'sd200, 1'b1);
    send_item(-16'sd30000, 1'b1);
    random_tracks(40);

    // Long output hold-off while the sender keeps offering items
    hold_req = 1'b1;
    random_tracks(40);
    // Sender pause until all output has drained
    wait_drained();
    random_tracks(20);

    foreach (steps_plan[p]) begin
      write_steps(steps_plan[p]);
      if (p == 0) begin
        send_item(-16'sd32768, 1'b1);
        send_item(16'sd32767, 1'b0);
      end
      if (p == 5) calm = 1'b1;
      random_tracks(55);
    end
    write_steps(RS_RESET);
    random_tracks(20);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d input items, %0d output transfers, %0d peaks, %0d tracks,",
             n_items, sb.results, sb.peaks, sb.tracks);
    $display("and %0d ramp_steps writes including 0, 16 and above the bound.", n_cfg);
    if (sb.errors == 0 && sb.expected_out.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: peak_limiter_gain_ramp_core.f
rtl/plgr_pkg.sv
rtl/plgr_div.sv
rtl/plgr_dp.sv
rtl/plgr_ctrl.sv
rtl/peak_limiter_gain_ramp_core.sv
sim/peak_limiter_gain_ramp_core_tb.sv
